/* rtl/core/pes_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pes_pkg
// Shared types and constants for the particle emitter step block.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int unsigned ValW = 24;
  localparam int unsigned CfgW = 18;
  localparam int unsigned TimeW = 48;
  localparam int unsigned CordicIters = 16;
  localparam int unsigned AngW = 34;

  localparam logic [1:0] OpSeed = 2'd0;
  localparam logic [1:0] OpStep = 2'd1;
  localparam logic [1:0] OpRead = 2'd2;

  localparam logic [1:0] RegSpawnSpeed = 2'd0;
  localparam logic [1:0] RegGravityX = 2'd1;
  localparam logic [1:0] RegGravityY = 2'd2;

  localparam logic signed [ValW-1:0] SatMax = 24'sh7FFFFF;
  localparam logic signed [ValW-1:0] SatMin = -24'sh800000;
  localparam logic signed [ValW-1:0] SpawnY = -24'sd65536;
  localparam logic signed [ValW-1:0] LimitY = -24'sd78643;
  localparam logic signed [ValW-1:0] LimitX = 24'sd98304;
  localparam logic signed [AngW-1:0] CordicGain = 34'sd652032874;

  localparam logic [31:0] HashGolden = 32'd2654435761;
  localparam logic [31:0] HashSalt = 32'h9E3779B9;
  localparam logic [31:0] HashMul = 32'h27d4eb2d;
  localparam logic [31:0] HashXor = 32'd61;

  // Datapath commands issued by the controller.
  typedef enum logic [2:0] {
    CmdNone,
    CmdRead,
    CmdUpdV,
    CmdUpdP,
    CmdHash,
    CmdCordic,
    CmdVel,
    CmdWrite
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic       respawn;   // write spawn values instead of integrated ones
    logic       seed;      // ms offset is zero
    logic [3:0] iter;      // CORDIC iteration or sub-step
  } ctrl_t;

  typedef struct packed {
    logic leave;           // particle left the view after the update
  } stat_t;

  function automatic logic signed [ValW-1:0] sat24(input logic signed [63:0] v);
    if (v > 64'(SatMax)) return SatMax;
    if (v < 64'(SatMin)) return SatMin;
    return v[ValW-1:0];
  endfunction

  function automatic logic signed [AngW-1:0] atan_q30(input logic [3:0] k);
    case (k)
      4'd0: return 34'sd843314856;
      4'd1: return 34'sd497837829;
      4'd2: return 34'sd263043836;
      4'd3: return 34'sd133525158;
      4'd4: return 34'sd67021686;
      4'd5: return 34'sd33543515;
      4'd6: return 34'sd16775850;
      4'd7: return 34'sd8388437;
      4'd8: return 34'sd4194282;
      4'd9: return 34'sd2097149;
      4'd10: return 34'sd1048575;
      4'd11: return 34'sd524287;
      4'd12: return 34'sd262143;
      4'd13: return 34'sd131071;
      4'd14: return 34'sd65535;
      default: return 34'sd32767;
    endcase
  endfunction

endpackage
`default_nettype wire

/* rtl/core/pes_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pes_ctrl
// Sequencer: walks the particle table for seed and step words and serves reads.
// ----------------------------------------------------------------------------
module pes_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_go_i,
  input  wire [1:0]           in_op_i,
  input  wire                 seeded_i,
  input  wire  pes_pkg::stat_t stat_i,
  input  wire                 last_i,
  output pes_pkg::ctrl_t      ctrl_o,
  output logic                busy_o,
  output logic                done_o,
  output logic                mark_seed_o,
  output logic                adv_time_o,
  output logic                next_idx_o,
  output logic                clr_idx_o
);

  typedef enum logic [3:0] {
    StIdle, StRead, StLoad, StUpdV, StUpdP, StChk, StHash, StHash2, StCordic,
    StVel, StVel2, StWrite, StDone
  } state_e;

  state_e     state_q;
  logic       seed_q, resp_q;
  logic [3:0] iter_q;

  always_comb begin
    ctrl_o = '{cmd: pes_pkg::CmdNone, respawn: resp_q, seed: seed_q, iter: iter_q};
    case (state_q)
      StRead, StLoad: ctrl_o.cmd = pes_pkg::CmdRead;
      StUpdV: ctrl_o.cmd = pes_pkg::CmdUpdV;
      StUpdP: ctrl_o.cmd = pes_pkg::CmdUpdP;
      StHash, StHash2: ctrl_o.cmd = pes_pkg::CmdHash;
      StCordic: ctrl_o.cmd = pes_pkg::CmdCordic;
      StVel, StVel2: ctrl_o.cmd = pes_pkg::CmdVel;
      StWrite: ctrl_o.cmd = pes_pkg::CmdWrite;
      default: ctrl_o.cmd = pes_pkg::CmdNone;
    endcase
    // Sub-step 1 of a memory read marks a host read rather than a table walk.
    if (state_q == StRead) ctrl_o.iter = 4'd1;
    if (state_q == StLoad) ctrl_o.iter = 4'd0;
    if (state_q == StHash2) ctrl_o.iter = 4'd1;
    if (state_q == StHash) ctrl_o.iter = 4'd0;
    if (state_q == StVel2) ctrl_o.iter = 4'd1;
    if (state_q == StVel) ctrl_o.iter = 4'd0;
  end

  assign busy_o = (state_q != StIdle);
  // The index moves at the accepting edge and at the write edge, so each
  // particle sees a stable index from its load to its write.
  assign clr_idx_o = (state_q == StIdle) && in_go_i;
  assign next_idx_o = (state_q == StWrite);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      seed_q <= 1'b0;
      resp_q <= 1'b0;
      iter_q <= '0;
      done_o <= 1'b0;
      mark_seed_o <= 1'b0;
      adv_time_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      mark_seed_o <= 1'b0;
      adv_time_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_go_i) begin
            if (in_op_i == pes_pkg::OpSeed) begin
              seed_q <= 1'b1;
              resp_q <= 1'b1;
              state_q <= StLoad;
            end else if (in_op_i == pes_pkg::OpStep && seeded_i) begin
              seed_q <= 1'b0;
              resp_q <= 1'b0;
              adv_time_o <= 1'b1;
              state_q <= StLoad;
            end else if (in_op_i == pes_pkg::OpRead) begin
              state_q <= StRead;
            end else begin
              state_q <= StDone;
            end
          end
        end
        StRead: state_q <= StDone;
        StLoad: state_q <= seed_q ? StHash : StUpdV;
        StUpdV: state_q <= StUpdP;
        StUpdP: state_q <= StChk;
        StChk: begin
          resp_q <= stat_i.leave;
          state_q <= stat_i.leave ? StHash : StWrite;
        end
        StHash: state_q <= StHash2;
        StHash2: begin
          iter_q <= '0;
          state_q <= StCordic;
        end
        StCordic: begin
          iter_q <= iter_q + 4'd1;
          if (iter_q == 4'(pes_pkg::CordicIters - 1)) state_q <= StVel;
        end
        StVel: state_q <= StVel2;
        StVel2: state_q <= StWrite;
        StWrite: begin
          if (last_i) begin
            if (seed_q) mark_seed_o <= 1'b1;
            state_q <= StDone;
          end else if (seed_q) begin
            state_q <= StLoad;
          end else begin
            resp_q <= 1'b0;
            state_q <= StLoad;
          end
        end
        StDone: begin
          done_o <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTH
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done pulse longer than a cycle");
  a_cordic_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StVel) |-> $past(state_q == StCordic)) else $error("cordic skipped");
  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_go_i && state_q == StIdle) |=> busy_o) else $error("word not started");
`endif

endmodule
`default_nettype wire

/* rtl/core/pes_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pes_dp
// Datapath: particle memories, Euler update, hash, CORDIC and spawn scaling.
// ----------------------------------------------------------------------------
module pes_dp #(
  parameter int unsigned NumParticles = 256,
  parameter int unsigned IdxW = 8
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  pes_pkg::ctrl_t         ctrl_i,
  input  wire                    in_go_i,
  input  wire [15:0]             time_step_i,
  input  wire [7:0]              particle_index_i,
  input  wire [17:0]             spawn_speed_i,
  input  wire signed [17:0]      gravity_x_i,
  input  wire signed [17:0]      gravity_y_i,
  input  wire                    adv_time_i,
  input  wire                    next_idx_i,
  input  wire                    clr_idx_i,
  output pes_pkg::stat_t         stat_o,
  output logic                   last_o,
  output logic signed [23:0]     rd_px_o,
  output logic signed [23:0]     rd_py_o,
  output logic signed [23:0]     rd_vx_o,
  output logic signed [23:0]     rd_vy_o,
  output logic                   rd_ok_o
);

  localparam int unsigned CntW = IdxW + 1;

  logic [47:0] pos_mem [NumParticles];
  logic [47:0] vel_mem [NumParticles];
  logic [47:0] pos_rd_q, vel_rd_q;

  logic [CntW-1:0] idx_q;
  logic [15:0]     dt_q;
  logic [47:0]     time_q;
  logic [31:0]     base_q;
  logic signed [23:0] px_q, py_q, vx_q, vy_q;
  logic [31:0]     key_q;
  logic [23:0]     h_q;
  logic signed [pes_pkg::AngW-1:0] cx_q, cy_q, cz_q;
  logic signed [23:0] sx_q, svx_q, svy_q;

  // Read index is latched on acceptance.
  logic [7:0] ridx_q;
  logic       rsel_q;
  logic       rd_cyc;

  logic [IdxW-1:0] addr;
  assign rd_cyc = (ctrl_i.cmd == pes_pkg::CmdRead) && (ctrl_i.iter == 4'd1);
  assign addr = rd_cyc ? IdxW'(ridx_q) : idx_q[IdxW-1:0];
  assign last_o = (idx_q == CntW'(NumParticles - 1));

  function automatic logic [31:0] mix24(input logic [31:0] k0);
    logic [31:0] k;
    k = (k0 ^ pes_pkg::HashXor) ^ (k0 >> 16);
    k = k + (k << 3);
    k = k ^ (k >> 4);
    k = k * pes_pkg::HashMul;
    k = k ^ (k >> 15);
    return {8'd0, k[23:0]};
  endfunction

  logic signed [63:0] prod_x, prod_y;
  logic [31:0] hmix;
  logic signed [pes_pkg::AngW-1:0] dx, dy;
  logic [3:0] sh;
  logic signed [63:0] vel_prod_q;
  logic signed [63:0] vel3;

  always_comb begin
    prod_x = '0;
    prod_y = '0;
    case (ctrl_i.cmd)
      pes_pkg::CmdUpdV: begin
        prod_x = 64'(gravity_x_i) * $signed({48'd0, dt_q});
        prod_y = 64'(gravity_y_i) * $signed({48'd0, dt_q});
      end
      pes_pkg::CmdUpdP: begin
        prod_x = 64'(vx_q) * $signed({48'd0, dt_q});
        prod_y = 64'(vy_q) * $signed({48'd0, dt_q});
      end
      pes_pkg::CmdVel: begin
        if (ctrl_i.iter == 4'd0) begin
          prod_x = 64'(cy_q) * $signed({46'd0, spawn_speed_i});
          prod_y = 64'(cx_q) * $signed({46'd0, spawn_speed_i});
        end else begin
          // The centered hash spans twice the 24-bit range before scaling.
          prod_x = 64'($signed({1'b0, h_q, 1'b0}) - 26'sd16777216) * 64'sd39322;
        end
      end
      default: ;
    endcase
    vel3 = vel_prod_q * 64'sd3;
    hmix = mix24(ctrl_i.iter[0] ? (key_q ^ pes_pkg::HashSalt) : key_q);
    sh = (ctrl_i.iter == 4'd0) ? 4'd0 : ctrl_i.iter;
    dx = cy_q >>> sh;
    dy = cx_q >>> sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      time_q <= '0;
      rd_ok_o <= 1'b0;
      rsel_q <= 1'b0;
    end else begin
      if (clr_idx_i) idx_q <= '0;
      else if (next_idx_i) idx_q <= idx_q + CntW'(1);
      if (adv_time_i) time_q <= time_q + 48'(dt_q);
      if (in_go_i) begin
        rsel_q <= (particle_index_i < 8'(NumParticles > 255 ? 255 : NumParticles)) ||
                  (NumParticles > 255);
      end
      rd_ok_o <= rd_cyc && rsel_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go_i) begin
      dt_q <= time_step_i;
      ridx_q <= particle_index_i;
    end
    pos_rd_q <= pos_mem[addr];
    vel_rd_q <= vel_mem[addr];
    base_q <= 32'((time_q * 64'd1000) >> 16);
    case (ctrl_i.cmd)
      pes_pkg::CmdRead: ;
      pes_pkg::CmdUpdV: begin
        vx_q <= pes_pkg::sat24(64'($signed(vel_rd_q[47:24])) +
                               ((prod_x + 64'sd32768) >>> 16));
        vy_q <= pes_pkg::sat24(64'($signed(vel_rd_q[23:0])) +
                               ((prod_y + 64'sd32768) >>> 16));
        px_q <= $signed(pos_rd_q[47:24]);
        py_q <= $signed(pos_rd_q[23:0]);
      end
      pes_pkg::CmdUpdP: begin
        px_q <= pes_pkg::sat24(64'(px_q) + ((prod_x + 64'sd32768) >>> 16));
        py_q <= pes_pkg::sat24(64'(py_q) + ((prod_y + 64'sd32768) >>> 16));
      end
      pes_pkg::CmdHash: begin
        if (ctrl_i.iter == 4'd0) begin
          h_q <= hmix[23:0];
        end else begin
          cz_q <= ($signed({10'd0, hmix[23:0]}) - 34'sd8388608) * 34'sd96;
          cx_q <= pes_pkg::CordicGain;
          cy_q <= '0;
        end
      end
      pes_pkg::CmdCordic: begin
        if (cz_q >= 0) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          cz_q <= cz_q - pes_pkg::atan_q30(ctrl_i.iter);
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          cz_q <= cz_q + pes_pkg::atan_q30(ctrl_i.iter);
        end
      end
      pes_pkg::CmdVel: begin
        if (ctrl_i.iter == 4'd0) begin
          svx_q <= pes_pkg::sat24((prod_x + 64'sd536870912) >>> 30);
          vel_prod_q <= prod_y;
        end else begin
          svy_q <= pes_pkg::sat24((vel3 + 64'sd1073741824) >>> 31);
          sx_q <= pes_pkg::sat24((prod_x + 64'sd8388608) >>> 24);
        end
      end
      pes_pkg::CmdWrite: begin
        if (ctrl_i.respawn) begin
          pos_mem[idx_q[IdxW-1:0]] <= {sx_q, pes_pkg::SpawnY};
          vel_mem[idx_q[IdxW-1:0]] <= {svx_q, svy_q};
        end else begin
          pos_mem[idx_q[IdxW-1:0]] <= {px_q, py_q};
          vel_mem[idx_q[IdxW-1:0]] <= {vx_q, vy_q};
        end
      end
      default: ;
    endcase
    // Hash key is registered from the index and the ms count.
    key_q <= 32'(idx_q) * pes_pkg::HashGolden +
             (ctrl_i.seed ? 32'd0 : base_q + 32'd13 * 32'(idx_q));
    rd_px_o <= $signed(pos_rd_q[47:24]);
    rd_py_o <= $signed(pos_rd_q[23:0]);
    rd_vx_o <= $signed(vel_rd_q[47:24]);
    rd_vy_o <= $signed(vel_rd_q[23:0]);
  end

  assign stat_o.leave = (py_q < pes_pkg::LimitY) || (px_q > pes_pkg::LimitX) ||
                        (px_q < -pes_pkg::LimitX);

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= CntW'(NumParticles)) else $error("index past table");
  a_time_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_time_i |=> time_q == $past(time_q + 48'(dt_q))) else $error("time advance");
  a_write_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_idx_i |-> !clr_idx_i) else $error("index clear and advance together");
`endif

endmodule
`default_nettype wire

/* rtl/core/particle_emitter_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// particle_emitter_step
// Fixed-point 2D particle table with Euler stepping and hashed respawn.
// ----------------------------------------------------------------------------
// One word at a time. A read goes through the read and done states before its
// result is registered; the next word is taken once the result has left the
// output register, not while the output is stalled. A step runs load, update,
// check and write per particle, plus hash, CORDIC and spawn scaling for each
// particle that respawns; a seed runs load, hash, CORDIC, scaling and write per
// particle. The 16-iteration CORDIC unit does one iteration per cycle. The
// result word (zero unless a read) is held in an output register.
module particle_emitter_step #(
  parameter int unsigned NUM_PARTICLES = 256
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire [1:0]         opcode_i,
  input  wire [15:0]        time_step_i,
  input  wire [7:0]         particle_index_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic signed [23:0] position_x_o,
  output logic signed [23:0] position_y_o,
  output logic signed [23:0] velocity_x_o,
  output logic signed [23:0] velocity_y_o,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire [1:0]         cfg_index_i,
  input  wire [31:0]        cfg_data_i
);

  localparam int unsigned IdxW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

  logic [17:0] spawn_speed_q;
  logic signed [17:0] gravity_x_q, gravity_y_q;
  logic seeded_q;
  logic in_go, busy, done, mark_seed, adv_time, next_idx, clr_idx, last, rd_ok;
  logic [1:0] op_q;
  pes_pkg::ctrl_t ctrl;
  pes_pkg::stat_t stat;
  logic signed [23:0] rpx, rpy, rvx, rvy;

  assign cfg_ready_o = 1'b1;
  // The cycle that loads the result register also holds off new words.
  assign in_stall_o = busy || done || out_valid_o;
  assign in_go = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spawn_speed_q <= 18'd39322;
      gravity_x_q <= '0;
      gravity_y_q <= -18'sd26214;
      seeded_q <= 1'b0;
      out_valid_o <= 1'b0;
      op_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pes_pkg::RegSpawnSpeed: spawn_speed_q <= cfg_data_i[17:0];
          pes_pkg::RegGravityX: gravity_x_q <= $signed(cfg_data_i[17:0]);
          pes_pkg::RegGravityY: gravity_y_q <= $signed(cfg_data_i[17:0]);
          default: ;
        endcase
      end
      if (in_go) op_q <= opcode_i;
      if (mark_seed) seeded_q <= 1'b1;
      if (done) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  logic rd_hold_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_hold_q <= 1'b0;
    else if (in_go) rd_hold_q <= 1'b0;
    else if (rd_ok && op_q == pes_pkg::OpRead) rd_hold_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      position_x_o <= rd_hold_q ? rpx : '0;
      position_y_o <= rd_hold_q ? rpy : '0;
      velocity_x_o <= rd_hold_q ? rvx : '0;
      velocity_y_o <= rd_hold_q ? rvy : '0;
    end
  end

  pes_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_go_i(in_go), .in_op_i(opcode_i), .seeded_i(seeded_q),
    .stat_i(stat), .last_i(last), .ctrl_o(ctrl), .busy_o(busy), .done_o(done),
    .mark_seed_o(mark_seed), .adv_time_o(adv_time), .next_idx_o(next_idx),
    .clr_idx_o(clr_idx)
  );

  pes_dp #(.NumParticles(NUM_PARTICLES), .IdxW(IdxW)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .in_go_i(in_go), .time_step_i,
    .particle_index_i, .spawn_speed_i(spawn_speed_q), .gravity_x_i(gravity_x_q),
    .gravity_y_i(gravity_y_q), .adv_time_i(adv_time), .next_idx_i(next_idx),
    .clr_idx_i(clr_idx), .stat_o(stat), .last_o(last), .rd_px_o(rpx),
    .rd_py_o(rpy), .rd_vx_o(rvx), .rd_vy_o(rvy), .rd_ok_o(rd_ok)
  );

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_go) else $error("word taken while busy");
  a_done_sets_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_o) else $error("result lost");
  a_seed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seeded_q |=> seeded_q) else $error("seed flag cleared");
`endif

endmodule
`default_nettype wire

/* test/particle_emitter_step_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_emitter_step_tb
// Self-checking bench for the particle emitter: a scoreboard keeps its own
// particle table and predicts each result word. Directed items come first,
// then random seed, step, read and unused-opcode words under several gravity
// and speed settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module particle_emitter_step_tb;

  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
  } particle_word_t;

  class emitter_scoreboard;
    int unsigned      launch_speed;
    int               accel_x;
    int               accel_y;
    int               tab_px[256];
    int               tab_py[256];
    int               tab_vx[256];
    int               tab_vy[256];
    longint unsigned  sim_clock;
    bit               primed;
    particle_word_t   pending[$];
    int               errors;

    function new();
      launch_speed = 39322;
      accel_x = 0;
      accel_y = -26214;
      sim_clock = 0;
      primed = 0;
      errors = 0;
    endfunction

    task report(input string what, input longint got, input longint want);
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    function int sat(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return int'(v);
    endfunction

    function longint rshift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint mix(input logic [31:0] key);
      logic [31:0] k;
      k = (key ^ pes_pkg::HashXor) ^ (key >> 16);
      k = k + (k << 3);
      k = k ^ (k >> 4);
      k = k * pes_pkg::HashMul;
      k = k ^ (k >> 15);
      return longint'(k & 32'hFFFFFF);
    endfunction

    function void rotate(input longint ang, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = ang;
      for (int k = 0; k < 16; k++) begin
        dx = (k == 0) ? y : (y >>> k);
        dy = (k == 0) ? x : (x >>> k);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(pes_pkg::atan_q30(4'(k)));
        end else begin
          x += dx; y -= dy; z += longint'(pes_pkg::atan_q30(4'(k)));
        end
      end
      c = x;
      s = y;
    endfunction

    function void respawn(input int p, input logic [31:0] ms);
      logic [31:0] key;
      longint h, g, c, s;
      key = 32'(p) * pes_pkg::HashGolden + ms;
      h = mix(key);
      g = mix(key ^ pes_pkg::HashSalt);
      tab_px[p] = sat(rshift((2 * h - (64'sd1 << 24)) * 39322, 24));
      tab_py[p] = -65536;
      rotate((g - (64'sd1 << 23)) * 96, c, s);
      tab_vx[p] = sat(rshift(s * longint'(launch_speed), 30));
      tab_vy[p] = sat(rshift(c * longint'(launch_speed) * 3, 31));
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [31:0] data);
      case (idx)
        pes_pkg::RegSpawnSpeed: launch_speed = data[17:0];
        pes_pkg::RegGravityX:   accel_x = int'($signed(data[17:0]));
        pes_pkg::RegGravityY:   accel_y = int'($signed(data[17:0]));
        default: ;
      endcase
    endfunction

    // Applies one accepted word to the table and queues the result it causes.
    function void note_word(input logic [1:0] op, input logic [15:0] dt_in,
                            input logic [7:0] idx);
      particle_word_t w;
      longint dt;
      logic [31:0] base;
      int nvx, nvy, npx, npy;
      w = '{0, 0, 0, 0};
      dt = longint'(dt_in);
      if (op == pes_pkg::OpSeed) begin
        for (int p = 0; p < 256; p++) respawn(p, 32'd0);
        primed = 1;
      end else if (op == pes_pkg::OpStep && primed) begin
        sim_clock = (sim_clock + 64'(dt)) & 64'hFFFF_FFFF_FFFF;
        base = 32'((sim_clock * 1000) >> 16);
        for (int p = 0; p < 256; p++) begin
          nvx = sat(tab_vx[p] + rshift(longint'(accel_x) * dt, 16));
          nvy = sat(tab_vy[p] + rshift(longint'(accel_y) * dt, 16));
          npx = sat(tab_px[p] + rshift(longint'(nvx) * dt, 16));
          npy = sat(tab_py[p] + rshift(longint'(nvy) * dt, 16));
          tab_vx[p] = nvx; tab_vy[p] = nvy;
          tab_px[p] = npx; tab_py[p] = npy;
          if (npy < -78643 || npx > 98304 || npx < -98304)
            respawn(p, base + 32'(13 * p));
        end
      end else if (op == pes_pkg::OpRead) begin
        w.pos_x = 24'(tab_px[idx]);
        w.pos_y = 24'(tab_py[idx]);
        w.vel_x = 24'(tab_vx[idx]);
        w.vel_y = 24'(tab_vy[idx]);
      end
      pending.push_back(w);
    endfunction

    task check_word(input particle_word_t got);
      particle_word_t want;
      if (pending.size() == 0) begin
        report("unexpected result word", got.pos_x, 0);
      end else begin
        want = pending.pop_front();
        if (got.pos_x !== want.pos_x) report("position_x", got.pos_x, want.pos_x);
        if (got.pos_y !== want.pos_y) report("position_y", got.pos_y, want.pos_y);
        if (got.vel_x !== want.vel_x) report("velocity_x", got.vel_x, want.vel_x);
        if (got.vel_y !== want.vel_y) report("velocity_y", got.vel_y, want.vel_y);
      end
    endtask
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [1:0] opcode_i;
  logic [15:0] time_step_i;
  logic [7:0] particle_index_i;
  logic out_valid_o, out_stall_i;
  logic signed [23:0] position_x_o, position_y_o, velocity_x_o, velocity_y_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  emitter_scoreboard sb = new();
  bit quiet;
  int stall_left;

  particle_emitter_step dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .time_step_i,
    .particle_index_i, .out_valid_o, .out_stall_i, .position_x_o, .position_y_o,
    .velocity_x_o, .velocity_y_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(64'd200_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output side: check, then pick the stall for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i)
        sb.check_word('{position_x_o, position_y_o, velocity_x_o, velocity_y_o});
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 30) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : 0;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [15:0] dt,
                           input logic [7:0] idx);
    int n;
    if ($urandom_range(0, 49) == 0) quiet = !quiet;
    opcode_i <= op;
    time_step_i <= dt;
    particle_index_i <= idx;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(op, dt, idx);
    n = gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every result word has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input int value);
    cfg_index_i <= idx;
    cfg_data_i <= 32'(value);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, 32'(value));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_word();
    int r;
    logic [15:0] dt;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 6) dt = 16'($urandom_range(0, 2000));
    else if ($urandom_range(0, 9) == 0) dt = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0;
    else dt = 16'($urandom);
    if (r < 68) send_word(pes_pkg::OpRead, 16'($urandom), 8'($urandom));
    else if (r < 91) send_word(pes_pkg::OpStep, dt, 8'($urandom));
    else if (r < 95) send_word(pes_pkg::OpSeed, 16'($urandom), 8'($urandom));
    else send_word(OpUnused, 16'($urandom), 8'($urandom));
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = '0;
    time_step_i = '0;
    particle_index_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    quiet = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Steps before the first seed must be ignored.
    send_word(pes_pkg::OpStep, 16'hFFFF, 8'd0);
    send_word(OpUnused, 16'hFFFF, 8'hFF);
    send_word(pes_pkg::OpSeed, 16'd0, 8'd0);
    send_word(pes_pkg::OpRead, 16'd0, 8'd0);
    send_word(pes_pkg::OpRead, 16'hFFFF, 8'hFF);
    send_word(pes_pkg::OpRead, 16'd0, 8'd128);
    send_word(pes_pkg::OpStep, 16'd0, 8'd0);
    send_word(pes_pkg::OpRead, 16'd0, 8'd3);
    send_word(pes_pkg::OpStep, 16'hFFFF, 8'd0);
    send_word(pes_pkg::OpRead, 16'd0, 8'd0);
    send_word(pes_pkg::OpRead, 16'd0, 8'd255);
    send_word(OpUnused, 16'd0, 8'd0);
    send_word(pes_pkg::OpStep, 16'd1, 8'hFF);
    send_word(pes_pkg::OpRead, 16'd0, 8'd7);
    // A second seed keeps the elapsed time.
    send_word(pes_pkg::OpSeed, 16'hFFFF, 8'hFF);
    send_word(pes_pkg::OpRead, 16'd0, 8'd0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_cfg(pes_pkg::RegSpawnSpeed, 0);
          write_cfg(pes_pkg::RegGravityX, -65536);
          write_cfg(pes_pkg::RegGravityY, 65536);
        end
        1: begin
          write_cfg(pes_pkg::RegSpawnSpeed, 131072);
          write_cfg(pes_pkg::RegGravityX, 65536);
          write_cfg(pes_pkg::RegGravityY, -65536);
        end
        2: begin
          write_cfg(pes_pkg::RegSpawnSpeed, $urandom_range(0, 131072));
          write_cfg(pes_pkg::RegGravityX, int'($urandom_range(0, 131072)) - 65536);
          write_cfg(pes_pkg::RegGravityY, int'($urandom_range(0, 131072)) - 65536);
        end
        default: begin
          write_cfg(pes_pkg::RegSpawnSpeed, 39322);
          write_cfg(pes_pkg::RegGravityX, 0);
          write_cfg(pes_pkg::RegGravityY, -26214);
        end
      endcase
      send_word(pes_pkg::OpSeed, 16'($urandom), 8'($urandom));
      for (int i = 0; i < 141; i++) begin
        random_word();
        if (phase == 1 && i == 70) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (sb.pending.size() != 0)
      sb.report("result words never returned", sb.pending.size(), 0);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/pes_pkg.sv
rtl/core/pes_ctrl.sv
rtl/core/pes_dp.sv
rtl/core/particle_emitter_step.sv
test/particle_emitter_step_tb.sv
